// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds on every clock edge outside reset.
`define TBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the following cycle.
`define TBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tbs_pkg.sv =====
package tbs_pkg;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned TICK_HZ = 1000;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [9:0] MS_TO_US = 10'd1000;
  localparam int unsigned US_PER_S = 1000000;
  localparam logic [31:0] MIN_INTERVAL_US = 32'(US_PER_S / TICK_HZ);

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_CREATE     = 3'd1,
    OP_DESTROY    = 3'd2,
    OP_START      = 3'd3,
    OP_STOP       = 3'd4,
    OP_SET_FLAGS  = 3'd5,
    OP_SET_IVAL   = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_DIRECT = 2'd1,
    KIND_POSTED = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_STATUS,
    ST_MUL,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic mul_en;
    logic exec_en;
    logic tick_status;
  } ctrl_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [31:0]       data;
  } ram_wr_t;

  // Returns a found bit above the index of the lowest unused slot.
  function automatic logic [SLOT_W:0] lowest_free(input logic [SLOTS-1:0] used);
    logic [SLOT_W:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        r = {1'b1, SLOT_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/tbs_time_ram.sv =====
module tbs_time_ram (
  input  logic                 clk_i,
  input  tbs_pkg::ram_wr_t     ival_wr_i,
  input  tbs_pkg::ram_wr_t     start_wr_i,
  input  logic                 rd_en_i,
  input  logic [tbs_pkg::SLOT_W-1:0] raddr_i,
  output logic [31:0]          ival_o,
  output logic [31:0]          start_o
);
  import tbs_pkg::*;

  logic [31:0] ival_mem [SLOTS];
  logic [31:0] start_mem [SLOTS];

  always_ff @(posedge clk_i) begin
    if (ival_wr_i.we) begin
      ival_mem[ival_wr_i.addr] <= ival_wr_i.data;
    end
    if (start_wr_i.we) begin
      start_mem[start_wr_i.addr] <= start_wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      ival_o  <= ival_mem[raddr_i];
      start_o <= start_mem[raddr_i];
    end
  end

endmodule

// ===== rtl/tbs_arith.sv =====
module tbs_arith (
  input  logic [31:0] now_us_i,
  input  logic [31:0] start_us_i,
  input  logic [31:0] interval_us_i,
  input  logic [22:0] interval_ms_i,
  output logic        expired_o,
  output logic [31:0] scaled_us_o
);
  import tbs_pkg::*;

  logic [31:0] elapsed;
  logic [32:0] product;

  assign elapsed     = now_us_i - start_us_i;
  assign expired_o   = (elapsed >= interval_us_i);
  assign product     = 33'(interval_ms_i) * 33'(MS_TO_US);
  assign scaled_us_o = product[31:0];

endmodule

// ===== rtl/timer_bank_scheduler.sv =====
// A tick request scans the slots one per cycle through a single elapsed-time
// compare unit fed by one RAM read port, and the block stays busy through the
// scan and the ST_DRAIN and ST_STATUS states after a tick is accepted. Every
// other request keeps it busy while it first scales the interval (ST_MUL) and
// then updates the slot (ST_EXEC). Results come out one per cycle on strobe_o,
// the expiry events of a tick first in slot order and then one status result
// with last_o set. The receiver cannot stall these results, and a new request
// can be accepted in the very cycle in which the final status result is shown.
`include "assert_macros.svh"

module timer_bank_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode_i,
  input  logic [3:0]  slot_i,
  input  logic [22:0] interval_ms_i,
  input  logic        flag_enabled_i,
  input  logic        flag_repeat_i,
  input  logic        flag_direct_i,
  input  logic        has_handler_i,
  input  logic [31:0] now_us_i,
  output logic        strobe_o,
  output logic [1:0]  kind_o,
  output logic [3:0]  timer_slot_o,
  output logic        ok_o,
  output logic        last_o
);
  import tbs_pkg::*;

  state_e state_q, state_d;
  ctrl_t  ctrl;

  logic              accept;
  logic [2:0]        mode_q;
  logic [3:0]        slot_q;
  logic [22:0]       ims_q;
  logic              fen_q, frep_q, fdir_q, fh_q;
  logic [31:0]       now_q;
  logic [31:0]       scaled_q;

  logic [SLOT_W-1:0] idx_q;
  logic              cmp_vld_q;
  logic [SLOT_W-1:0] cmp_idx_q;

  logic [SLOTS-1:0]  used_q, en_q, rep_q, dir_q, hnd_q;
  logic [SLOTS-1:0]  used_d, en_d, rep_d, dir_d, hnd_d;

  ram_wr_t           ival_wr, start_wr;
  logic [31:0]       rd_ival, rd_start;
  logic              expired;
  logic [31:0]       scaled_us;
  logic [31:0]       clamped_us;

  logic [SLOT_W-1:0] sidx;
  logic              slot_ok;
  logic [SLOT_W:0]   free_w;
  logic [SLOT_W-1:0] free_idx;

  logic              res_vld_q, res_vld_d;
  kind_e             res_kind_q, res_kind_d;
  logic [3:0]        res_ts_q, res_ts_d;
  logic              res_ok_q, res_ok_d;
  logic              res_last_q, res_last_d;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = (mode_i == OP_TICK) ? ST_SCAN : ST_MUL;
        end
      end
      ST_SCAN: begin
        if (idx_q == SLOT_W'(SLOTS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_STATUS;
      ST_STATUS: state_d = ST_IDLE;
      ST_MUL:    state_d = ST_EXEC;
      ST_EXEC:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ST_SCAN:   ctrl.rd_en = 1'b1;
      ST_STATUS: ctrl.tick_status = 1'b1;
      ST_MUL:    ctrl.mul_en = 1'b1;
      ST_EXEC:   ctrl.exec_en = 1'b1;
      default:   ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= ctrl.rd_en;
      if (accept) begin
        idx_q <= '0;
      end else if (ctrl.rd_en) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= idx_q;
    if (accept) begin
      mode_q <= mode_i;
      slot_q <= slot_i;
      ims_q  <= interval_ms_i;
      fen_q  <= flag_enabled_i;
      frep_q <= flag_repeat_i;
      fdir_q <= flag_direct_i;
      fh_q   <= has_handler_i;
      now_q  <= now_us_i;
    end
    if (ctrl.mul_en) begin
      scaled_q <= scaled_us;
    end
  end

  tbs_time_ram u_ram (
    .clk_i      (clk_i),
    .ival_wr_i  (ival_wr),
    .start_wr_i (start_wr),
    .rd_en_i    (ctrl.rd_en),
    .raddr_i    (idx_q),
    .ival_o     (rd_ival),
    .start_o    (rd_start)
  );

  tbs_arith u_arith (
    .now_us_i      (now_q),
    .start_us_i    (rd_start),
    .interval_us_i (rd_ival),
    .interval_ms_i (ims_q),
    .expired_o     (expired),
    .scaled_us_o   (scaled_us)
  );

  assign sidx       = SLOT_W'(slot_q);
  assign slot_ok    = (32'(slot_q) < 32'(SLOTS)) && used_q[sidx];
  assign free_w     = lowest_free(used_q);
  assign free_idx   = free_w[SLOT_W-1:0];
  assign clamped_us = (scaled_q < MIN_INTERVAL_US) ? MIN_INTERVAL_US : scaled_q;

  always_comb begin
    used_d = used_q;
    en_d   = en_q;
    rep_d  = rep_q;
    dir_d  = dir_q;
    hnd_d  = hnd_q;
    ival_wr  = '{we: 1'b0, addr: sidx, data: scaled_q};
    start_wr = '{we: 1'b0, addr: sidx, data: now_q};
    res_vld_d  = 1'b0;
    res_kind_d = KIND_STATUS;
    res_ts_d   = '0;
    res_ok_d   = 1'b0;
    res_last_d = 1'b0;

    if (cmp_vld_q && used_q[cmp_idx_q] && en_q[cmp_idx_q] && expired) begin
      if (hnd_q[cmp_idx_q]) begin
        res_vld_d  = 1'b1;
        res_kind_d = dir_q[cmp_idx_q] ? KIND_DIRECT : KIND_POSTED;
        res_ts_d   = 4'(cmp_idx_q);
        res_ok_d   = 1'b1;
      end
      if (rep_q[cmp_idx_q]) begin
        start_wr.we   = 1'b1;
        start_wr.addr = cmp_idx_q;
      end else begin
        en_d[cmp_idx_q] = 1'b0;
      end
    end

    if (ctrl.tick_status) begin
      res_vld_d  = 1'b1;
      res_ok_d   = 1'b1;
      res_last_d = 1'b1;
    end

    if (ctrl.exec_en) begin
      res_vld_d  = 1'b1;
      res_last_d = 1'b1;
      unique case (mode_q)
        OP_CREATE: begin
          if ((ims_q != '0) && free_w[SLOT_W]) begin
            used_d[free_idx] = 1'b1;
            en_d[free_idx]   = fen_q;
            rep_d[free_idx]  = frep_q;
            dir_d[free_idx]  = fdir_q;
            hnd_d[free_idx]  = fh_q;
            ival_wr          = '{we: 1'b1, addr: free_idx, data: clamped_us};
            start_wr.we      = 1'b1;
            start_wr.addr    = free_idx;
            res_ok_d         = 1'b1;
            res_ts_d         = 4'(free_idx);
          end
        end
        OP_DESTROY: begin
          if (slot_ok) begin
            used_d[sidx] = 1'b0;
            en_d[sidx]   = 1'b0;
            rep_d[sidx]  = 1'b0;
            dir_d[sidx]  = 1'b0;
            hnd_d[sidx]  = 1'b0;
            res_ok_d     = 1'b1;
          end
        end
        OP_START: begin
          if (slot_ok) begin
            start_wr.we = 1'b1;
            en_d[sidx]  = 1'b1;
            res_ok_d    = 1'b1;
          end
        end
        OP_STOP: begin
          if (slot_ok) begin
            en_d[sidx] = 1'b0;
            res_ok_d   = 1'b1;
          end
        end
        OP_SET_FLAGS: begin
          if (slot_ok) begin
            en_d[sidx]  = fen_q;
            rep_d[sidx] = frep_q;
            dir_d[sidx] = fdir_q;
            start_wr.we = fen_q;
            res_ok_d    = 1'b1;
          end
        end
        OP_SET_IVAL: begin
          if (slot_ok) begin
            ival_wr.we  = 1'b1;
            start_wr.we = en_q[sidx];
            res_ok_d    = 1'b1;
          end
        end
        default: res_ok_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      en_q      <= '0;
      rep_q     <= '0;
      dir_q     <= '0;
      hnd_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      used_q    <= used_d;
      en_q      <= en_d;
      rep_q     <= rep_d;
      dir_q     <= dir_d;
      hnd_q     <= hnd_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q <= res_kind_d;
    res_ts_q   <= res_ts_d;
    res_ok_q   <= res_ok_d;
    res_last_q <= res_last_d;
  end

  assign strobe_o     = res_vld_q;
  assign kind_o       = res_kind_q;
  assign timer_slot_o = res_ts_q;
  assign ok_o         = res_ok_q;
  assign last_o       = res_last_q;

  `TBS_ASSERT(a_last_means_idle, !(res_vld_q && res_last_q) || (state_q == ST_IDLE), "final result while a request is still in work")
  `TBS_ASSERT_NEXT(a_accept_goes_busy, accept, busy, "accepted request did not make the block busy")
  `TBS_ASSERT(a_expiry_not_last, !(res_vld_q && (res_kind_q != KIND_STATUS)) || !res_last_q, "expiry result marked as final")
  `TBS_ASSERT(a_cmp_in_scan, !cmp_vld_q || (state_q == ST_SCAN) || (state_q == ST_DRAIN), "slot compare outside a tick scan")

endmodule

// ===== tb/sv/tb_timer_bank_scheduler.sv =====
module tb_timer_bank_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import tbs_pkg::*;

  localparam logic [2:0]  MODE_UNKNOWN    = 3'd7;
  localparam logic [31:0] US_PER_MS       = 32'd1000;
  localparam int          RANDOM_REQUESTS = 360;
  localparam int          QUIET_LIMIT     = 2000;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  slot;
    logic [22:0] interval_ms;
    logic        enabled;
    logic        auto_repeat;
    logic        direct;
    logic        has_handler;
    logic [31:0] now_us;
  } timer_req_t;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] slot;
    logic       ok;
    logic       last;
  } timer_result_t;

  class timer_bank_tracker;
    bit              used[SLOTS];
    bit              enabled[SLOTS];
    bit              auto_repeat[SLOTS];
    bit              direct[SLOTS];
    bit              has_handler[SLOTS];
    logic [31:0]     interval_us[SLOTS];
    logic [31:0]     start_us[SLOTS];
    timer_result_t   pending_results[$];
    int              failures;
    int              requests;
    int              ticks;
    int              results;
    int              expiries;
    int              most_expiries;
    int              full_rejects;

    function void queue_result(kind_e k, logic [3:0] s, logic ok, logic last);
      timer_result_t e;
      e.kind = k;
      e.slot = s;
      e.ok   = ok;
      e.last = last;
      pending_results.push_back(e);
    endfunction

    function void note_request(timer_req_t r);
      logic [31:0] elapsed;
      logic [31:0] iv;
      logic [3:0]  alloc;
      bit          ok;
      bit          valid;
      int          fired;
      ok    = 1'b0;
      alloc = '0;
      fired = 0;
      valid = used[r.slot];
      requests++;
      case (r.op)
        OP_TICK: begin
          ticks++;
          for (int i = 0; i < SLOTS; i++) begin
            elapsed = r.now_us - start_us[i];
            if (used[i] && enabled[i] && elapsed >= interval_us[i]) begin
              if (has_handler[i]) begin
                queue_result(direct[i] ? KIND_DIRECT : KIND_POSTED, 4'(i), 1'b1, 1'b0);
                fired++;
              end
              if (auto_repeat[i]) begin
                start_us[i] = r.now_us;
              end else begin
                enabled[i] = 1'b0;
              end
            end
          end
          expiries += fired;
          if (fired > most_expiries) begin
            most_expiries = fired;
          end
          ok = 1'b1;
        end
        OP_CREATE: begin
          if (r.interval_ms != '0) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!ok && !used[i]) begin
                iv = 32'(r.interval_ms) * US_PER_MS;
                if (iv < MIN_INTERVAL_US) begin
                  iv = MIN_INTERVAL_US;
                end
                used[i]        = 1'b1;
                enabled[i]     = r.enabled;
                auto_repeat[i] = r.auto_repeat;
                direct[i]      = r.direct;
                has_handler[i] = r.has_handler;
                interval_us[i] = iv;
                start_us[i]    = r.now_us;
                ok             = 1'b1;
                alloc          = 4'(i);
              end
            end
            if (!ok) begin
              full_rejects++;
            end
          end
        end
        OP_DESTROY: begin
          if (valid) begin
            used[r.slot]        = 1'b0;
            enabled[r.slot]     = 1'b0;
            auto_repeat[r.slot] = 1'b0;
            direct[r.slot]      = 1'b0;
            has_handler[r.slot] = 1'b0;
            ok                  = 1'b1;
          end
        end
        OP_START: begin
          if (valid) begin
            start_us[r.slot] = r.now_us;
            enabled[r.slot]  = 1'b1;
            ok               = 1'b1;
          end
        end
        OP_STOP: begin
          if (valid) begin
            enabled[r.slot] = 1'b0;
            ok              = 1'b1;
          end
        end
        OP_SET_FLAGS: begin
          if (valid) begin
            enabled[r.slot]     = r.enabled;
            auto_repeat[r.slot] = r.auto_repeat;
            direct[r.slot]      = r.direct;
            if (r.enabled) begin
              start_us[r.slot] = r.now_us;
            end
            ok = 1'b1;
          end
        end
        OP_SET_IVAL: begin
          if (valid) begin
            interval_us[r.slot] = 32'(r.interval_ms) * US_PER_MS;
            if (enabled[r.slot]) begin
              start_us[r.slot] = r.now_us;
            end
            ok = 1'b1;
          end
        end
        default: begin
        end
      endcase
      queue_result(KIND_STATUS, alloc, ok, 1'b1);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [3:0] slot, logic ok, logic last);
      timer_result_t e;
      results++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, kind %0d slot %0d ok %0d last %0d",
                 $time, kind, slot, ok, last);
        failures++;
        return;
      end
      e = pending_results.pop_front();
      compare_field("kind", 32'(e.kind), 32'(kind));
      compare_field("timer_slot", 32'(e.slot), 32'(slot));
      compare_field("ok", 32'(e.ok), 32'(ok));
      compare_field("last", 32'(e.last), 32'(last));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  timer_req_t  req_q;
  logic        strobe_o;
  logic [1:0]  kind_o;
  logic [3:0]  timer_slot_o;
  logic        ok_o;
  logic        last_o;

  timer_bank_tracker tracker;
  logic [31:0]       clock_us;
  bit                steady;
  int                quiet_cycles;

  timer_bank_scheduler u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (req_q.op),
    .slot_i         (req_q.slot),
    .interval_ms_i  (req_q.interval_ms),
    .flag_enabled_i (req_q.enabled),
    .flag_repeat_i  (req_q.auto_repeat),
    .flag_direct_i  (req_q.direct),
    .has_handler_i  (req_q.has_handler),
    .now_us_i       (req_q.now_us),
    .strobe_o       (strobe_o),
    .kind_o         (kind_o),
    .timer_slot_o   (timer_slot_o),
    .ok_o           (ok_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (strobe_o) begin
        tracker.check_result(kind_o, timer_slot_o, ok_o, last_o);
      end
      if (start && !busy) begin
        tracker.note_request(req_q);
      end
      if (strobe_o || (start && !busy)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic timer_req_t make_request(logic [2:0] op, logic [3:0] slot,
                                              logic [22:0] ims, logic en, logic rep,
                                              logic dir, logic hnd, logic [31:0] now);
    timer_req_t r;
    r.op          = op;
    r.slot        = slot;
    r.interval_ms = ims;
    r.enabled     = en;
    r.auto_repeat = rep;
    r.direct      = dir;
    r.has_handler = hnd;
    r.now_us      = now;
    return r;
  endfunction

  task automatic send_request(timer_req_t r);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 35) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_q <= r;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    timer_req_t r;
    int         pick;
    int         sel;
    bit         burst;
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_q        = '0;
    steady       = 1'b0;
    quiet_cycles = 0;
    tracker      = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short directed sequence across the wrap of the microsecond counter.
    clock_us = 32'hFFFF_FA00;
    send_request(make_request(OP_TICK, 4'd0, 23'd0, 1'b0, 1'b0, 1'b0, 1'b0, clock_us));
    send_request(make_request(OP_DESTROY, 4'd15, 23'd0, 1'b1, 1'b1, 1'b1, 1'b1, clock_us));
    send_request(make_request(OP_START, 4'd0, 23'd0, 1'b0, 1'b0, 1'b0, 1'b0, clock_us));
    send_request(make_request(OP_STOP, 4'd5, 23'd0, 1'b0, 1'b0, 1'b0, 1'b0, clock_us));
    send_request(make_request(OP_SET_FLAGS, 4'd10, 23'd0, 1'b1, 1'b1, 1'b1, 1'b1, clock_us));
    send_request(make_request(OP_SET_IVAL, 4'd3, 23'd5, 1'b0, 1'b0, 1'b0, 1'b0, clock_us));
    send_request(make_request(MODE_UNKNOWN, 4'd0, 23'd7, 1'b1, 1'b1, 1'b1, 1'b1, clock_us));
    send_request(make_request(OP_CREATE, 4'd0, 23'd0, 1'b1, 1'b1, 1'b1, 1'b1, clock_us));
    send_request(make_request(OP_CREATE, 4'd0, 23'd1, 1'b1, 1'b1, 1'b1, 1'b1, clock_us));
    // This interval wraps to below the minimum tick period and gets clamped.
    send_request(make_request(OP_CREATE, 4'd0, 23'd4294968, 1'b1, 1'b0, 1'b0, 1'b1,
                              clock_us));
    send_request(make_request(OP_CREATE, 4'd0, 23'h7FFFFF, 1'b0, 1'b0, 1'b0, 1'b0,
                              clock_us));
    send_request(make_request(OP_CREATE, 4'd0, 23'd4294967, 1'b1, 1'b1, 1'b0, 1'b1,
                              clock_us));
    clock_us += 32'd2000;
    send_request(make_request(OP_TICK, 4'd0, 23'd0, 1'b0, 1'b0, 1'b0, 1'b0, clock_us));
    send_request(make_request(OP_SET_IVAL, 4'd0, 23'd0, 1'b0, 1'b0, 1'b0, 1'b0, clock_us));
    send_request(make_request(OP_TICK, 4'd0, 23'd0, 1'b0, 1'b0, 1'b0, 1'b0, clock_us));
    send_request(make_request(OP_SET_FLAGS, 4'd2, 23'd0, 1'b1, 1'b1, 1'b1, 1'b0, clock_us));
    send_request(make_request(OP_START, 4'd1, 23'd0, 1'b0, 1'b0, 1'b0, 1'b0, clock_us));
    send_request(make_request(OP_STOP, 4'd0, 23'd0, 1'b0, 1'b0, 1'b0, 1'b0, clock_us));
    clock_us += 32'd5000;
    send_request(make_request(OP_TICK, 4'd0, 23'd0, 1'b0, 1'b0, 1'b0, 1'b0, clock_us));
    send_request(make_request(OP_DESTROY, 4'd1, 23'd0, 1'b0, 1'b0, 1'b0, 1'b0, clock_us));
    send_request(make_request(OP_CREATE, 4'd0, 23'd2, 1'b1, 1'b0, 1'b1, 1'b1, clock_us));
    send_request(make_request(OP_SET_FLAGS, 4'd3, 23'd0, 1'b0, 1'b0, 1'b0, 1'b0, clock_us));
    send_request(make_request(OP_TICK, 4'd0, 23'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF));

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      burst  = (n >= 40 && n < 110);
      steady = (n >= 200 && n < 280);
      pick   = $urandom_range(0, 99);
      if (burst) begin
        pick = (pick < 50) ? 40 : ((pick < 90) ? 0 : pick);
      end
      r.slot = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 99) < 80) begin
        repeat (16) begin
          if (!tracker.used[r.slot]) begin
            r.slot = 4'($urandom_range(0, 15));
          end
        end
      end
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        r.interval_ms = '0;
      end else if (sel < 12) begin
        r.interval_ms = 23'($urandom());
      end else if (sel < 17) begin
        r.interval_ms = 23'($urandom_range(4294960, 4294975));
      end else begin
        r.interval_ms = 23'($urandom_range(1, 12));
      end
      r.enabled     = ($urandom_range(0, 99) < 75);
      r.auto_repeat = ($urandom_range(0, 99) < 60);
      r.direct      = 1'($urandom_range(0, 1));
      r.has_handler = ($urandom_range(0, 99) < 80);
      if (pick < 35) begin
        r.op = OP_TICK;
      end else if (pick < 50) begin
        r.op = OP_CREATE;
      end else if (pick < 59) begin
        r.op = OP_DESTROY;
      end else if (pick < 70) begin
        r.op = OP_START;
      end else if (pick < 78) begin
        r.op = OP_STOP;
      end else if (pick < 89) begin
        r.op = OP_SET_FLAGS;
      end else if (pick < 98) begin
        r.op = OP_SET_IVAL;
      end else begin
        r.op = MODE_UNKNOWN;
      end
      if ($urandom_range(0, 99) < 4) begin
        clock_us = $urandom();
      end else if (r.op == OP_TICK) begin
        clock_us += 32'($urandom_range(0, 4000));
      end else begin
        clock_us += 32'($urandom_range(0, 300));
      end
      r.now_us = clock_us;
      send_request(r);
    end
    start <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 4) @(posedge clk_i);

    $display("Run covered %0d requests including %0d ticks; %0d results checked, %0d expiry events.",
             tracker.requests, tracker.ticks, tracker.results, tracker.expiries);
    $display("Most expiry events from one tick: %0d; creates refused on a full bank: %0d.",
             tracker.most_expiries, tracker.full_rejects);
    if (tracker.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
